### hdl/obd_pkg.sv
// Shared types, codes and helper functions for the OBD PID reply decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package obd_pkg;

   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 27;
   localparam int SNAP_DATA_W = 32;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_ECHO   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 2'd2;

   // Formula selector codes.
   localparam logic [2:0] FORMULA_TEMP_C   = 3'd0;
   localparam logic [2:0] FORMULA_AB_100TH = 3'd1;
   localparam logic [2:0] FORMULA_AB_10TH  = 3'd2;
   localparam logic [2:0] FORMULA_AB       = 3'd3;
   localparam logic [2:0] FORMULA_A        = 3'd4;
   localparam logic [2:0] FORMULA_BOOST    = 3'd5;
   localparam logic [2:0] FORMULA_KELVIN   = 3'd6;
   localparam logic [2:0] FORMULA_ANY_SET  = 3'd7;

   // Register indexes (byte address / 4).
   localparam logic [1:0] REG_ECHO_PATTERN   = 2'd0;
   localparam logic [1:0] REG_ECHO_LENGTH    = 2'd1;
   localparam logic [1:0] REG_FORMULA_SELECT = 2'd2;

   localparam logic [3:0] ECHO_LENGTH_RESET = 4'd4;

   // Scale factors and offsets of the milli-unit formulas.
   localparam logic [9:0] SCALE_1    = 10'd1;
   localparam logic [9:0] SCALE_10   = 10'd10;
   localparam logic [9:0] SCALE_100  = 10'd100;
   localparam logic [9:0] SCALE_1000 = 10'd1000;
   localparam logic [16:0] TEMP_BIAS = 17'd40;
   localparam logic [VALUE_W-1:0] BOOST_OFFSET  = 27'h7FFFC18;  // -1000
   localparam logic [VALUE_W-1:0] KELVIN_OFFSET = 27'h7FBD502;  // -273150

   typedef struct packed {
      logic [31:0] echo_pattern;
      logic [3:0]  echo_length;
      logic [2:0]  formula_select;
   } cfg_type;

   // Reply state captured on the last character; data is left aligned.
   typedef struct packed {
      logic                   found;
      logic [3:0]             count;
      logic [SNAP_DATA_W-1:0] data;
   } snap_type;

   // Returns {valid, nibble}; lower-case letters map like upper-case ones.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/obd_csr.sv
// APB-style configuration registers of the OBD PID reply decoder.
// Depends on obd_pkg for the register indexes and the configuration type.
`timescale 1ns / 1ps
`default_nettype none

module obd_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [3:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output obd_pkg::cfg_type     cfg
);

   obd_pkg::cfg_type cfg_ff;
   obd_pkg::cfg_type cfg_in;
   logic             write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_paddr[3:2])
            obd_pkg::REG_ECHO_PATTERN:   cfg_in.echo_pattern   = csr_pwdata;
            obd_pkg::REG_ECHO_LENGTH:    cfg_in.echo_length    = csr_pwdata[3:0];
            obd_pkg::REG_FORMULA_SELECT: cfg_in.formula_select = csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_pattern   <= 32'd0;
         cfg_ff.echo_length    <= obd_pkg::ECHO_LENGTH_RESET;
         cfg_ff.formula_select <= obd_pkg::FORMULA_TEMP_C;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         obd_pkg::REG_ECHO_PATTERN:   csr_prdata = cfg_ff.echo_pattern;
         obd_pkg::REG_ECHO_LENGTH:    csr_prdata = {28'd0, cfg_ff.echo_length};
         obd_pkg::REG_FORMULA_SELECT: csr_prdata = {29'd0, cfg_ff.formula_select};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/obd_reply_tracker.sv
// Per-character filter, echo matcher and data-digit collector of the decoder.
// Depends on obd_pkg; hands a registered reply snapshot to the value stage.
`timescale 1ns / 1ps
`default_nettype none

module obd_reply_tracker #(
   parameter int MAX_KEPT_DIGITS = 63,
   parameter int ECHO_MAX_DIGITS = 8,
   parameter int DATA_BYTES      = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire obd_pkg::cfg_type  cfg,
   output logic                   snap_valid,
   input  wire logic              snap_ready,
   output obd_pkg::snap_type      snap
);

   localparam int KW = $clog2(MAX_KEPT_DIGITS + 1);
   localparam int RW = 4 * ECHO_MAX_DIGITS;
   localparam int DW = 8 * DATA_BYTES;
   localparam int DIGITS = 2 * DATA_BYTES;

   logic [RW-1:0] recent_ff, recent_in;
   logic [KW-1:0] kept_ff, kept_in;
   logic          found_ff, found_in;
   logic [DW-1:0] data_ff, data_in;
   logic [3:0]    dcount_ff, dcount_in;
   logic          snap_valid_ff, snap_valid_in;
   obd_pkg::snap_type snap_ff, snap_in;

   logic       accept;
   logic [4:0] hex;
   logic       take;
   logic [3:0] len;
   logic       match;
   logic       window_full;

   assign req_tready = !snap_valid_ff || snap_ready;
   assign accept     = req_tvalid && req_tready;
   assign hex        = obd_pkg::hex_decode(req_tdata);
   assign take       = hex[4] && (kept_ff < KW'(MAX_KEPT_DIGITS));
   assign len        = (cfg.echo_length > 4'(ECHO_MAX_DIGITS)) ?
                       4'(ECHO_MAX_DIGITS) : cfg.echo_length;
   assign window_full = ({1'b0, kept_ff} + (KW+1)'(1)) >= (KW+1)'(len);

   always_comb begin
      recent_in     = recent_ff;
      kept_in       = kept_ff;
      found_in      = found_ff;
      data_in       = data_ff;
      dcount_in     = dcount_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      snap_in       = snap_ff;
      match         = 1'b1;

      if (accept) begin
         if (take) begin
            kept_in = KW'(kept_ff + KW'(1));
            if (found_ff || len == 4'd0) begin
               // Echo already seen (or empty echo): this digit is data.
               found_in = 1'b1;
               if (dcount_ff < 4'(DIGITS)) begin
                  for (int i = 0; i < DIGITS; i++) begin
                     if (dcount_ff == 4'(i)) begin
                        data_in[DW-1-4*i -: 4] = hex[3:0];
                     end
                  end
                  dcount_in = 4'(dcount_ff + 4'd1);
               end
            end else begin
               recent_in = {recent_ff[RW-5:0], hex[3:0]};
               for (int i = 0; i < ECHO_MAX_DIGITS; i++) begin
                  if (i < int'(len) &&
                      recent_in[4*i +: 4] != cfg.echo_pattern[4*i +: 4]) begin
                     match = 1'b0;
                  end
               end
               if (window_full && match) begin
                  found_in = 1'b1;
               end
            end
         end

         if (req_tlast) begin
            snap_valid_in = 1'b1;
            snap_in.found = found_in;
            snap_in.count = dcount_in;
            snap_in.data  = obd_pkg::SNAP_DATA_W'(data_in) << (obd_pkg::SNAP_DATA_W - DW);
            recent_in     = '0;
            kept_in       = '0;
            found_in      = 1'b0;
            data_in       = '0;
            dcount_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff     <= '0;
         kept_ff       <= '0;
         found_ff      <= 1'b0;
         data_ff       <= '0;
         dcount_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         recent_ff     <= recent_in;
         kept_ff       <= kept_in;
         found_ff      <= found_in;
         data_ff       <= data_in;
         dcount_ff     <= dcount_in;
         snap_valid_ff <= snap_valid_in;
      end
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

`ifndef NO_ASSERTIONS
   a_kept_capped: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= KW'(MAX_KEPT_DIGITS))
      else $error("kept digit count exceeds cap");

   a_dcount_capped: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= 4'(DIGITS))
      else $error("data digit count exceeds capacity");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> kept_ff == '0 && !found_ff && dcount_ff == '0 && snap_valid_ff)
      else $error("reply state not cleared after last character");
`endif

endmodule

`default_nettype wire

### hdl/obd_value_calc.sv
// Status and formula stage of the decoder: one constant multiply and offset.
// Depends on obd_pkg; feeds the registered result word of the top level.
`timescale 1ns / 1ps
`default_nettype none

module obd_value_calc #(
   parameter int DATA_BYTES = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [2:0]                      formula_select,
   input  wire logic                            snap_valid,
   output logic                                 snap_ready,
   input  wire obd_pkg::snap_type               snap,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [obd_pkg::STATUS_W-1:0]         status,
   output logic [obd_pkg::VALUE_W-1:0]          value_milli
);

   logic                          valid_ff, valid_in;
   logic [obd_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [obd_pkg::VALUE_W-1:0]   value_ff, value_in;

   logic [7:0]            byte_a, byte_b;
   logic [15:0]           ab;
   logic                  wide;
   logic                  any_set;
   logic signed [16:0]    operand;
   logic [9:0]            scale;
   logic [obd_pkg::VALUE_W-1:0] offset;
   logic signed [27:0]    product;

   assign snap_ready = !valid_ff || rsp_tready;
   assign byte_a = snap.data[31:24];
   assign byte_b = (snap.count >= 4'd4) ? snap.data[23:16] : 8'd0;
   assign ab     = {byte_a, byte_b};
   assign wide   = formula_select inside {obd_pkg::FORMULA_AB_100TH, obd_pkg::FORMULA_AB_10TH,
                                          obd_pkg::FORMULA_AB, obd_pkg::FORMULA_BOOST,
                                          obd_pkg::FORMULA_KELVIN};

   always_comb begin
      any_set = 1'b0;
      for (int k = 0; k < DATA_BYTES; k++) begin
         if (snap.count >= 4'(2 * (k + 1)) && snap.data[31-8*k -: 8] != 8'd0) begin
            any_set = 1'b1;
         end
      end
   end

   always_comb begin
      operand   = 17'sd0;
      scale     = 10'd0;
      offset    = '0;
      status_in = obd_pkg::STATUS_OK;
      if (!snap.found) begin
         status_in = obd_pkg::STATUS_NO_ECHO;
      end else if (snap.count < (wide ? 4'd4 : 4'd2)) begin
         status_in = obd_pkg::STATUS_TOO_SHORT;
      end else begin
         case (formula_select)
            obd_pkg::FORMULA_TEMP_C: begin
               operand = $signed(17'(byte_a) - obd_pkg::TEMP_BIAS);
               scale   = obd_pkg::SCALE_1000;
            end
            obd_pkg::FORMULA_AB_100TH: begin
               operand = $signed(17'(ab));
               scale   = obd_pkg::SCALE_10;
            end
            obd_pkg::FORMULA_AB_10TH: begin
               operand = $signed(17'(ab));
               scale   = obd_pkg::SCALE_100;
            end
            obd_pkg::FORMULA_AB: begin
               operand = $signed(17'(ab));
               scale   = obd_pkg::SCALE_1000;
            end
            obd_pkg::FORMULA_A: begin
               operand = $signed(17'(byte_a));
               scale   = obd_pkg::SCALE_1000;
            end
            obd_pkg::FORMULA_BOOST: begin
               operand = $signed(17'(ab));
               scale   = obd_pkg::SCALE_1;
               offset  = obd_pkg::BOOST_OFFSET;
            end
            obd_pkg::FORMULA_KELVIN: begin
               operand = $signed(17'(ab));
               scale   = obd_pkg::SCALE_100;
               offset  = obd_pkg::KELVIN_OFFSET;
            end
            default: begin
               operand = any_set ? 17'sd1 : 17'sd0;
               scale   = obd_pkg::SCALE_1000;
            end
         endcase
      end
   end

   assign product  = operand * $signed({1'b0, scale});
   assign value_in = obd_pkg::VALUE_W'(product[obd_pkg::VALUE_W-1:0] + offset);

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (snap_valid && snap_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (snap_valid && snap_ready) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign status      = status_ff;
   assign value_milli = value_ff;

`ifndef NO_ASSERTIONS
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != obd_pkg::STATUS_OK |-> value_ff == '0)
      else $error("nonzero value reported with an error status");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> status_ff <= obd_pkg::STATUS_TOO_SHORT)
      else $error("undefined status code");

   a_snap_to_result: assert property (@(posedge clock) disable iff (reset)
      snap_valid && snap_ready |=> valid_ff)
      else $error("snapshot taken but no result word pending");
`endif

endmodule

`default_nettype wire

### hdl/obd_pid_response_decoder_unit.sv
// Top level of the OBD PID reply decoder: stream ports, APB registers.
// Depends on obd_pkg, obd_csr, obd_reply_tracker and obd_value_calc.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one reply character per word on the req_ stream, with
// tlast set on the final character of a reply, and accepts a new word in
// every cycle unless stalled. Only hex digits are kept (lower case counts
// as upper case), up to MAX_KEPT_DIGITS per reply. The first place where
// the configured echo pattern of echo_length digits appears ends the
// search, and up to 2*DATA_BYTES digits after it become data bytes A, B,
// C, D. For each character that carries tlast exactly one result word
// comes out on the rsp_ stream: a status (0 ok, 1 echo not found, 2 data
// too short) and the selected formula's value times 1000 as a signed
// integer, zero on error. The reply state clears itself after every last
// character. The snapshot register of the reply tracker captures the
// reply at the edge that accepts the last character, and the result
// register behind the constant multiplier loads it from there as soon
// as that register is free, which raises rsp_tvalid. Both stages hand
// words on while the next ones arrive, so throughput is one character
// per cycle as long as results are taken; when both stages hold a word
// and rsp_tready is low, req_tready drops. Registers: echo_pattern at
// 0x0, echo_length at 0x4 (reset value 4, values above ECHO_MAX_DIGITS
// act as that maximum, 0 means every digit is data), formula_select at 0x8.
// Write them only while no reply is in progress and no result is pending.
module obd_pid_response_decoder_unit #(
   parameter int MAX_KEPT_DIGITS = 63,
   parameter int ECHO_MAX_DIGITS = 8,
   parameter int DATA_BYTES      = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] reply_char
   input  wire logic        req_tlast,    // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [1:0] status, [28:2] value_milli, rest zero
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   obd_pkg::cfg_type                cfg;
   obd_pkg::snap_type               snap;
   logic                            snap_valid;
   logic                            snap_ready;
   logic [obd_pkg::STATUS_W-1:0]    status;
   logic [obd_pkg::VALUE_W-1:0]     value_milli;

   // Configuration registers.
   obd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Character filter and echo match; registers a snapshot on tlast.
   obd_reply_tracker #(
      .MAX_KEPT_DIGITS (MAX_KEPT_DIGITS),
      .ECHO_MAX_DIGITS (ECHO_MAX_DIGITS),
      .DATA_BYTES      (DATA_BYTES)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Status decision and scaled formula value into the result register.
   obd_value_calc #(
      .DATA_BYTES (DATA_BYTES)
   ) u_calc (
      .clock          (clock),
      .reset          (reset),
      .formula_select (cfg.formula_select),
      .snap_valid     (snap_valid),
      .snap_ready     (snap_ready),
      .snap           (snap),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .value_milli    (value_milli)
   );

   // Pack the result word: status in the low bits, value above it.
   assign rsp_tdata = {3'd0, value_milli, status};

endmodule

`default_nettype wire

### bench/obd_pid_response_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for obd_pid_response_decoder_unit. It streams reply characters,
// predicts every result word from its own decoder model and checks each field.
// Depends on obd_pkg and the decoder RTL.

module obd_pid_response_decoder_unit_tb;

   localparam int KEPT_LIMIT       = 63;  // digits kept per reply
   localparam int ECHO_LIMIT       = 8;   // longest echo in digits
   localparam int DATA_DIGIT_LIMIT = 8;   // four data bytes
   localparam int PHASE_COUNT      = 16;
   localparam int CHARS_PER_PHASE  = 75;

   // One character on the request stream, and one decoded result.
   typedef struct packed {
      logic [7:0] code;
      logic       tail;
   } char_word_type;

   typedef struct packed {
      logic [obd_pkg::STATUS_W-1:0] status;
      logic [obd_pkg::VALUE_W-1:0]  value;
   } reply_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   wire  [31:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'h0;
   logic [31:0] csr_pwdata  = 32'h0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   obd_pid_response_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] reply_char
      .req_tlast   (req_tlast),    // is_last
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [1:0] status, [28:2] value_milli
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies, updated as the bench writes them.
   logic [31:0] echo_pattern_q = 32'h0;
   logic [3:0]  echo_length_q  = obd_pkg::ECHO_LENGTH_RESET;
   logic [2:0]  formula_q      = obd_pkg::FORMULA_TEMP_C;

   // Reply state of the decoder model.
   logic [31:0] recent_digits = 32'h0;
   int          kept_digits   = 0;
   logic        echo_seen     = 1'b0;
   logic [31:0] data_digits   = 32'h0;
   int          data_count    = 0;

   char_word_type    pending_chars[$];
   reply_result_type expected_results[$];
   logic [7:0]       reply_buf[$];

   int chars_in_flight = 0;  // queued but not yet accepted by the decoder
   int char_total      = 0;
   int mismatch_count  = 0;

   int               burst_left = 1;
   int               gap_left   = 0;
   int               stall_tick = 0;
   int               stall_mode = 0;
   char_word_type    drive_word;
   reply_result_type want;
   logic [1:0]       got_status;
   logic [26:0]      got_value;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A run that hangs, for instance on a lost result, ends here.
   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, what);
   endfunction

   function automatic void clear_reply_state();
      recent_digits = 32'h0;
      kept_digits   = 0;
      echo_seen     = 1'b0;
      data_digits   = 32'h0;
      data_count    = 0;
   endfunction

   // Decoder model: takes one accepted character and, on the last one of a
   // reply, queues the result word that the decoder must produce.
   function automatic void decode_char(input logic [7:0] code, input logic tail);
      int               nib;
      int               span;
      logic [31:0]      mask;
      logic             wide;
      logic             any_set;
      longint           a;
      longint           b;
      longint           ab;
      longint           val;
      logic [1:0]       status;
      reply_result_type res;
      nib = -1;
      if (code >= 8'h30 && code <= 8'h39) nib = code - 8'h30;
      else if (code >= 8'h41 && code <= 8'h46) nib = code - 8'h37;
      else if (code >= 8'h61 && code <= 8'h66) nib = code - 8'h57;

      // Once the digit cap is reached, later digits have no effect at all.
      if (nib >= 0 && kept_digits < KEPT_LIMIT) begin
         span = (echo_length_q > ECHO_LIMIT) ? ECHO_LIMIT : echo_length_q;
         // An empty echo matches ahead of the first digit.
         if (!echo_seen && span == 0) echo_seen = 1'b1;
         if (echo_seen) begin
            if (data_count < DATA_DIGIT_LIMIT) begin
               data_digits[28 - 4 * data_count +: 4] = nib[3:0];
               data_count++;
            end
         end else begin
            recent_digits = {recent_digits[27:0], nib[3:0]};
            if (kept_digits + 1 >= span) begin
               mask = (span >= ECHO_LIMIT) ? 32'hFFFF_FFFF : (32'h1 << (4 * span)) - 32'h1;
               if ((recent_digits & mask) == (echo_pattern_q & mask)) echo_seen = 1'b1;
            end
         end
         kept_digits++;
      end
      if (!tail) return;

      status = obd_pkg::STATUS_OK;
      val    = 0;
      if (!echo_seen) begin
         status = obd_pkg::STATUS_NO_ECHO;
      end else begin
         wide = formula_q inside {obd_pkg::FORMULA_AB_100TH, obd_pkg::FORMULA_AB_10TH,
                                  obd_pkg::FORMULA_AB, obd_pkg::FORMULA_BOOST,
                                  obd_pkg::FORMULA_KELVIN};
         if (data_count < (wide ? 4 : 2)) begin
            status = obd_pkg::STATUS_TOO_SHORT;
         end else begin
            a  = data_digits[31:24];
            b  = (data_count >= 4) ? data_digits[23:16] : 0;
            ab = a * 256 + b;
            case (formula_q)
               obd_pkg::FORMULA_TEMP_C:   val = (a - 40) * 1000;
               obd_pkg::FORMULA_AB_100TH: val = ab * 10;
               obd_pkg::FORMULA_AB_10TH:  val = ab * 100;
               obd_pkg::FORMULA_AB:       val = ab * 1000;
               obd_pkg::FORMULA_A:        val = a * 1000;
               obd_pkg::FORMULA_BOOST:    val = ab - 1000;
               obd_pkg::FORMULA_KELVIN:   val = ab * 100 - 273150;
               default: begin
                  // Only complete bytes count toward the any-byte flag.
                  any_set = 1'b0;
                  for (int k = 0; k < 4; k++) begin
                     if (data_count >= 2 * (k + 1) && data_digits[31 - 8 * k -: 8] != 8'h00)
                        any_set = 1'b1;
                  end
                  val = any_set ? 1000 : 0;
               end
            endcase
         end
      end
      res.status = status;
      res.value  = val[obd_pkg::VALUE_W-1:0];
      expected_results.push_back(res);
      clear_reply_state();
   endfunction

   // Request driver: sends queued characters in bursts with random gaps. The
   // result side's ready follows one of four stall patterns, redrawn at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               drive_word = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= drive_word.code;
               req_tlast  <= drive_word.tail;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         stall_tick++;
         if (stall_tick % 64 == 0) stall_mode = $urandom_range(3);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(1);
            2:       rsp_tready <= (stall_tick % 3 == 0);
            default: rsp_tready <= (stall_tick % 8 == 7);
         endcase
      end
   end

   // Monitor: feeds every accepted character to the model and checks every
   // accepted result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            chars_in_flight--;
            decode_char(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[1:0];
            got_value  = rsp_tdata[28:2];
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("result word with none expected: status %0d value %0d",
                                       got_status, $signed(got_value)));
            end else begin
               want = expected_results.pop_front();
               if (got_status != want.status)
                  note_mismatch($sformatf("status expected %0d got %0d",
                                          want.status, got_status));
               if (got_value != want.value)
                  note_mismatch($sformatf("value_milli expected %0d got %0d",
                                          $signed(want.value), $signed(got_value)));
            end
         end
      end
   end

   function automatic void push_char(input logic [7:0] code, input logic tail);
      char_word_type w;
      w.code = code;
      w.tail = tail;
      pending_chars.push_back(w);
      chars_in_flight++;
      char_total++;
   endfunction

   // Queues the built reply with tlast on its final character; noisy replies
   // may also carry stray tlast marks in the middle.
   function automatic void close_reply(input logic stray_tails);
      foreach (reply_buf[i])
         push_char(reply_buf[i], (i == reply_buf.size() - 1) ||
                                 (stray_tails && $urandom_range(7) == 0));
      reply_buf.delete();
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) reply_buf.push_back(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) return 8'h30 + nib;
      return (($urandom_range(1) == 0) ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   function automatic logic [7:0] filler();
      logic [7:0] picks[6] = '{8'h20, 8'h0D, 8'h0A, 8'h3E, 8'h2E, 8'h47};
      return picks[$urandom_range(5)];
   endfunction

   function automatic int data_len();
      int picks[12] = '{0, 1, 2, 3, 4, 4, 4, 6, 8, 8, 10, 12};
      return picks[$urandom_range(11)];
   endfunction

   function automatic void add_digits(input int n);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(3) == 0) reply_buf.push_back(8'h20);
         reply_buf.push_back(hex_char($urandom_range(15)));
      end
   endfunction

   // Adds the first n digits of the configured echo; one digit may be spoiled.
   function automatic void add_echo(input int span, input int n, input int spoil);
      logic [3:0] nib;
      for (int i = 0; i < n; i++) begin
         nib = echo_pattern_q[4 * (span - 1 - i) +: 4];
         if (i == spoil) nib = nib ^ 4'($urandom_range(1, 15));
         reply_buf.push_back(hex_char(nib));
      end
   endfunction

   function automatic void make_reply();
      int shape;
      int span;
      int n;
      int spot;
      shape = $urandom_range(19);
      span  = (echo_length_q > ECHO_LIMIT) ? ECHO_LIMIT : echo_length_q;
      repeat ($urandom_range(2)) reply_buf.push_back(filler());
      if (shape < 12) begin
         // Well-formed reply, sometimes with stray digits ahead of the echo.
         if ($urandom_range(3) == 0) add_digits($urandom_range(1, 3));
         add_echo(span, span, -1);
         add_digits(data_len());
      end else if (shape < 14) begin
         // A partial echo first, so the match has to restart.
         add_echo(span, $urandom_range(span), -1);
         add_echo(span, span, -1);
         add_digits(data_len());
      end else if (shape < 16) begin
         add_echo(span, span, (span > 0) ? $urandom_range(span - 1) : -1);
         add_digits(data_len());
      end else if (shape < 19) begin
         repeat ($urandom_range(1, 10)) reply_buf.push_back(8'($urandom_range(255)));
      end else begin
         // Long reply that runs past the digit cap; the echo may come too late.
         n    = $urandom_range(55, 75);
         spot = $urandom_range(70);
         for (int i = 0; i < n; i++) begin
            if (i == spot) add_echo(span, span, -1);
            reply_buf.push_back(hex_char($urandom_range(15)));
         end
      end
      if ($urandom_range(1) == 1) reply_buf.push_back(filler());
      close_reply(shape >= 16 && shape < 19);
   endfunction

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         obd_pkg::REG_ECHO_PATTERN:   echo_pattern_q = data;
         obd_pkg::REG_ECHO_LENGTH:    echo_length_q  = data[3:0];
         obd_pkg::REG_FORMULA_SELECT: formula_q      = data[2:0];
         default: ;
      endcase
   endtask

   // Returns once every queued character is taken and every result has come,
   // plus a short pause for the two-stage result pipeline.
   task automatic wait_idle();
      while (chars_in_flight != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int          length_plan[PHASE_COUNT];
      logic [31:0] pattern;
      int          target;
      length_plan = '{1, 8, 0, 15, 2, 4, 9, 3, 5, 6, 7, 8, 12, 1, 4, 8};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed replies under the reset settings: echo "0000", formula A-40.
      add_text("0000ff");                   // A at its top value
      close_reply(1'b0);
      reply_buf.push_back(8'h00);           // character extremes, no hex digit
      reply_buf.push_back(8'hFF);
      add_text("/:@G`g");                   // neighbors of the hex ranges
      close_reply(1'b0);
      add_text("0000a");                    // one data digit: too short
      close_reply(1'b0);
      add_text("000000");                   // A of zero gives a negative value
      close_reply(1'b0);
      wait_idle();

      // Random phases; each drains fully before the registers change.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) pattern = 32'h0;
         else if (phase == 1) pattern = 32'hFFFF_FFFF;
         else pattern = $urandom();
         write_csr(obd_pkg::REG_ECHO_PATTERN, pattern);
         // Junk above the register width must be dropped.
         write_csr(obd_pkg::REG_ECHO_LENGTH,
                   ($urandom() & 32'hFFFF_FFF0) | 32'(length_plan[phase]));
         write_csr(obd_pkg::REG_FORMULA_SELECT,
                   ($urandom() & 32'hFFFF_FFF8) | 32'(phase % 8));
         target = char_total + CHARS_PER_PHASE;
         while (char_total < target) make_reply();
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (expected_results.size() != 0) note_mismatch("results still expected at the end");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/obd_pkg.sv
hdl/obd_csr.sv
hdl/obd_reply_tracker.sv
hdl/obd_value_calc.sv
hdl/obd_pid_response_decoder_unit.sv
bench/obd_pid_response_decoder_unit_tb.sv
